@@ hw/rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/sem_pkg.sv @@
package sem_pkg;
	localparam int PIX_W = 24;
	localparam int SUM_W = 17;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic fe;
	} sem_mask_t;
endpackage

@@ hw/rtl/sobel_edge_magnitude_rgb_unit.sv @@
// 3x3 sobel edge magnitude, per rgb channel, zero padding at frame edges
// s_axis: tdata = {blue, green, red} (red in bits 7:0), tuser = command
//   command 0 carries a pixel, 1 is a drain item after the last pixel of a frame
// m_axis: tdata = {blue, green, red} magnitudes, tlast = frame_end
// cfg: we/addr/wdata, index 0 image_width, 1 image_height; write only when idle
// each output belongs to the pixel width+1 transactions earlier; after a frame
// send width+1 drain items to flush. a drain item inside the frame is dropped
// an item that produces a result passes the line store read and window update,
// the sum of squares, eight square root iterations for the three channels in
// parallel and the load into the output register; the next item is taken in the
// cycle after that load
// an item that produces no result ends after the line store read and window update
// a result waiting in the output register does not block the input; when
// m_axis_tready stays low the next result holds in the last stage until it drains
// reset clears counters, window and valid flags; the line store is not cleared
module sobel_edge_magnitude_rgb_unit
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_red, out_green, out_blue
	output logic        m_axis_tlast,  // frame_end
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
`include "assert_macros.svh"
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {S_IDLE, S_RD, S_CALC, S_MAG} state_t;
	state_t state_q;

	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [CW-1:0] w_eff;
	logic [16:0] h_eff;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [16:0] in_row_q, out_row_q;
	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] val_q;
	logic emit_q;
	logic [AW-1:0] rd_col;
	logic [AW-1:0] col_s1;
	logic [PIX_W-1:0] top_rd, mid_rd;
	sem_mask_t mask_q;
	logic mag_start;
	logic [2:0] mag_busy;
	logic [7:0] mag [3];
	logic [SUM_W-1:0] sums [3];
	logic drain, acc;
	logic out_load;

	always_comb begin
		if (width_q == 12'd0) begin
			w_eff = CW'(1);
		end else if ({1'b0, width_q} > 13'(MAX_WIDTH) && MAX_WIDTH < 4096) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		h_eff = (height_q == 16'd0) ? 17'd1 : {1'b0, height_q};
	end

	assign drain = in_row_q >= h_eff;
	assign s_axis_tready = (state_q == S_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready && (drain || !s_axis_tuser);
	assign out_load = (state_q == S_MAG) && (mag_busy == 3'b000) &&
		(!m_axis_tvalid || m_axis_tready);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top (
		.clk(clk), .we(state_q == S_RD), .waddr(col_s1), .wdata(mid_rd),
		.re(acc), .raddr(rd_col), .rdata(top_rd)
	);
	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid (
		.clk(clk), .we(state_q == S_RD), .waddr(col_s1), .wdata(val_q),
		.re(acc), .raddr(rd_col), .rdata(mid_rd)
	);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic signed [11:0] gx, gy;
			logic signed [21:0] gx_w, gy_w;
			logic [7:0] p [3][3];
			logic [21:0] sx, sy;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p[r][c] = win_q[r][c][8*ch +: 8];
					if ((r == 0 && !mask_q.top_ok) || (r == 2 && !mask_q.bot_ok) ||
					    (c == 0 && !mask_q.left_ok) || (c == 2 && !mask_q.right_ok)) begin
						p[r][c] = 8'd0;
					end
				end
			end
			gx = $signed({4'd0, p[0][2]}) - $signed({4'd0, p[0][0]})
			   + $signed({3'd0, p[1][2], 1'b0}) - $signed({3'd0, p[1][0], 1'b0})
			   + $signed({4'd0, p[2][2]}) - $signed({4'd0, p[2][0]});
			gy = $signed({4'd0, p[2][0]}) - $signed({4'd0, p[0][0]})
			   + $signed({3'd0, p[2][1], 1'b0}) - $signed({3'd0, p[0][1], 1'b0})
			   + $signed({4'd0, p[2][2]}) - $signed({4'd0, p[0][2]});
			gx_w = 22'(gx);
			gy_w = 22'(gy);
			sx = $unsigned(gx_w * gx_w);
			sy = $unsigned(gy_w * gy_w);
			sums[ch] = (sx + sy > 22'd131071) ? 17'h1FFFF : SUM_W'(sx + sy);
		end
	end

	assign mag_start = (state_q == S_CALC);

	for (genvar g = 0; g < 3; g++) begin : g_mag
		sem_mag u_mag (
			.clk(clk), .arst_n(arst_n), .start(mag_start), .s(sums[g]),
			.busy(mag_busy[g]), .mag(mag[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 12'd640;
			height_q <= 16'd480;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
			emit_q <= 1'b0;
			val_q <= '0;
			col_s1 <= '0;
			mask_q <= '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_WIDTH) begin
					width_q <= cfg_wdata[11:0];
				end else begin
					height_q <= cfg_wdata;
				end
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						val_q <= drain ? '0 : s_axis_tdata;
						col_s1 <= rd_col;
						emit_q <= (in_row_q >= 17'd2) || (in_row_q == 17'd1 && in_col_q != '0);
						if (in_col_q + CW'(1) >= w_eff) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + 17'd1;
						end else begin
							in_col_q <= in_col_q + CW'(1);
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= win_q[r][2];
					end
					win_q[0][2] <= top_rd;
					win_q[1][2] <= mid_rd;
					win_q[2][2] <= val_q;
					mask_q.top_ok <= out_row_q != '0;
					mask_q.bot_ok <= out_row_q + 17'd1 < h_eff;
					mask_q.left_ok <= out_col_q != '0;
					mask_q.right_ok <= out_col_q + CW'(1) < w_eff;
					mask_q.fe <= (out_row_q + 17'd1 >= h_eff) && (out_col_q + CW'(1) >= w_eff);
					state_q <= emit_q ? S_CALC : S_IDLE;
				end
				S_CALC: begin
					state_q <= S_MAG;
				end
				S_MAG: begin
					if (out_load) begin
						m_axis_tdata <= {mag[2], mag[1], mag[0]};
						m_axis_tlast <= mask_q.fe;
						if (mask_q.fe) begin
							in_col_q <= '0;
							in_row_q <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
						end else if (out_col_q + CW'(1) >= w_eff) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 17'd1;
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		rd_col = (in_col_q >= CW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : AW'(in_col_q);
	end

	`ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`ASSERT_NXT(a_acc_to_rd, clk, arst_n, acc, state_q == S_RD)
	`ASSERT_IMP(a_mag_sync, clk, arst_n, state_q == S_MAG,
		mag_busy == 3'b000 || mag_busy == 3'b111)
endmodule

@@ hw/rtl/sem_ram.sv @@
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hw/rtl/sem_mag.sv @@
module sem_mag
	import sem_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   s,
	output logic               busy,
	output logic [7:0]         mag
);
	logic [SUM_W-1:0] s_q;
	logic [7:0]       n_q;
	logic [3:0]       bit_q;
	logic [7:0]       t;
	logic [15:0]      sq;
	logic [16:0]      nn;

	assign t  = n_q | (8'd1 << bit_q[2:0]);
	assign sq = t * t;
	assign nn = {1'b0, 16'(n_q) * 16'(n_q)} + {9'd0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			bit_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			bit_q <= 4'd7;
		end else if (busy) begin
			if (bit_q == 4'd0) begin
				busy <= 1'b0;
			end
			bit_q <= bit_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= s;
			n_q <= '0;
		end else if (busy && {1'b0, sq} <= s_q) begin
			n_q <= t;
		end
	end

	always_comb begin
		if (s_q > 17'd65280) begin
			mag = 8'd255;
		end else if (s_q > nn) begin
			mag = n_q + 8'd1;
		end else begin
			mag = n_q;
		end
	end
endmodule

@@ verif/sobel_edge_magnitude_rgb_unit_test.sv @@
module sobel_edge_magnitude_rgb_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;
	localparam bit CMD_PIXEL = 1'b0;
	localparam bit CMD_DRAIN = 1'b1;
	localparam int LINE_DEPTH = 2048;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [23:0] rgb;
		logic        frame_end;
	} edge_pixel_t;

	class edge_magnitude_predictor;
		int unsigned image_width;
		int unsigned image_height;
		logic [23:0] line_store [0:2*LINE_DEPTH-1];
		logic [23:0] win [0:2][0:2];
		int unsigned in_col, in_row, out_col, out_row;
		edge_pixel_t pending_pixels[$];
		int errors;

		function new();
			image_width = 640;
			image_height = 480;
			foreach (line_store[i]) line_store[i] = '0;
			foreach (win[r, c]) win[r][c] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, int unsigned value);
			if (idx == REG_IMAGE_WIDTH) image_width = value & 12'hfff;
			else image_height = value & 16'hffff;
		endfunction

		function int unsigned eff_width();
			if (image_width == 0) return 1;
			if (image_width > LINE_DEPTH) return LINE_DEPTH;
			return image_width;
		endfunction

		function int unsigned eff_height();
			return image_height == 0 ? 1 : image_height;
		endfunction

		function bit frame_open();
			return in_col != 0 || in_row != 0;
		endfunction

		function bit at_drain();
			return in_row >= eff_height();
		endfunction

		function logic [7:0] root_rounded(int s);
			int n;
			n = 0;
			if (s > 65280) return 8'd255;
			for (int b = 128; b != 0; b = b >> 1)
				if ((n + b) * (n + b) <= s) n = n + b;
			if (s > n * n + n) n++;
			return n[7:0];
		endfunction

		function void note_input(bit cmd, logic [23:0] data);
			int unsigned w, h, col;
			logic [23:0] val, top, mid;
			bit emit, top_ok, bot_ok, left_ok, right_ok, fe;
			int gx, gy, v, kx, ky;
			edge_pixel_t res;
			w = eff_width();
			h = eff_height();
			if (!at_drain() && cmd == CMD_DRAIN) return;
			val = at_drain() ? 24'd0 : data;
			col = in_col >= LINE_DEPTH ? LINE_DEPTH - 1 : in_col;
			top = line_store[LINE_DEPTH + col];
			mid = line_store[col];
			line_store[LINE_DEPTH + col] = mid;
			line_store[col] = val;
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = val;
			emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (!emit) return;
			top_ok = out_row != 0;
			bot_ok = out_row + 1 < h;
			left_ok = out_col != 0;
			right_ok = out_col + 1 < w;
			for (int ch = 0; ch < 3; ch++) begin
				gx = 0;
				gy = 0;
				for (int r = 0; r < 3; r++) begin
					if ((r == 0 && !top_ok) || (r == 2 && !bot_ok)) continue;
					for (int c = 0; c < 3; c++) begin
						if ((c == 0 && !left_ok) || (c == 2 && !right_ok)) continue;
						v = win[r][c][8*ch +: 8];
						kx = (c - 1) * (r == 1 ? 2 : 1);
						ky = (r - 1) * (c == 1 ? 2 : 1);
						gx += kx * v;
						gy += ky * v;
					end
				end
				res.rgb[8*ch +: 8] = root_rounded(gx * gx + gy * gy);
			end
			fe = out_row + 1 >= h && out_col + 1 >= w;
			res.frame_end = fe;
			pending_pixels.push_back(res);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			if (fe) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
			end
		endfunction

		function void check_result(logic [23:0] rgb, logic last);
			edge_pixel_t exp_px;
			if (pending_pixels.size() == 0) begin
				$error("unexpected output transaction rgb=%h last=%b", rgb, last);
				errors++;
				return;
			end
			exp_px = pending_pixels.pop_front();
			if (rgb[7:0] !== exp_px.rgb[7:0]) begin
				$error("out_red expected %0d actual %0d", exp_px.rgb[7:0], rgb[7:0]);
				errors++;
			end
			if (rgb[15:8] !== exp_px.rgb[15:8]) begin
				$error("out_green expected %0d actual %0d", exp_px.rgb[15:8], rgb[15:8]);
				errors++;
			end
			if (rgb[23:16] !== exp_px.rgb[23:16]) begin
				$error("out_blue expected %0d actual %0d", exp_px.rgb[23:16], rgb[23:16]);
				errors++;
			end
			if (last !== exp_px.frame_end) begin
				$error("frame_end expected %0b actual %0b", exp_px.frame_end, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_wdata;

	edge_magnitude_predictor sb;
	int cycles;
	int random_items;
	bit quiet;

	sobel_edge_magnitude_rgb_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function int draw_gap();
		if (quiet) return 0;
		return $urandom_range(0, 8);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side: random stalls, check every transaction
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	task automatic send_item(bit cmd, logic [23:0] rgb);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= rgb;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, rgb);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		cfg_we <= 1'b1;
		cfg_addr <= REG_IMAGE_WIDTH;
		cfg_wdata <= w[15:0];
		@(posedge clk);
		sb.write_reg(REG_IMAGE_WIDTH, w);
		cfg_addr <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h[15:0];
		@(posedge clk);
		sb.write_reg(REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drain items until the frame closes, some as pixels whose data is dropped
	task automatic flush_frame();
		while (sb.frame_open()) begin
			if ($urandom_range(0, 7) == 0) send_item(CMD_PIXEL, 24'($urandom));
			else send_item(CMD_DRAIN, 24'($urandom));
		end
	endtask

	task automatic random_frame(bit count_items);
		int unsigned n;
		n = sb.eff_width() * sb.eff_height();
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) send_item(CMD_DRAIN, 24'($urandom));
			case ($urandom_range(0, 5))
				0: send_item(CMD_PIXEL, {$urandom_range(0, 1) ? 8'hff : 8'h00,
					$urandom_range(0, 1) ? 8'hff : 8'h00,
					$urandom_range(0, 1) ? 8'hff : 8'h00});
				default: send_item(CMD_PIXEL, 24'($urandom));
			endcase
			if (count_items) random_items++;
		end
		flush_frame();
	endtask

	initial begin
		sb = new();
		cycles = 0;
		random_items = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 checkerboard of extremes, a drain inside the frame, a pixel in drain
		set_size(3, 3);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_item(CMD_DRAIN, 24'hffffff);
			send_item(CMD_PIXEL, (i % 2) ? 24'hffffff : 24'h000000);
		end
		send_item(CMD_PIXEL, 24'hffffff);
		flush_frame();
		wait_idle();

		// zero width and height read as one
		set_size(0, 0);
		send_item(CMD_PIXEL, 24'h80ff01);
		flush_frame();
		wait_idle();

		set_size(1, 7);
		random_frame(1'b0);
		wait_idle();

		while (random_items < 700) begin
			quiet = $urandom_range(0, 4) == 0;
			set_size($urandom_range(1, 12), $urandom_range(1, 6));
			random_frame(1'b1);
			if ($urandom_range(0, 1)) wait_idle();
			else s_axis_tvalid <= 1'b0;
			while (sb.pending_pixels.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		wait_idle();
		if (sb.errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
